[hw/rtl/a2i_pkg.sv]
`default_nettype none

package a2i_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned MaxEdgesDef    = 120;
  localparam int unsigned WeightBitsDef  = 16;

  // Fixed field widths of the ports.
  localparam int unsigned EntryW = 16;
  localparam int unsigned CfgW   = 5;

  // Vertex count after reset, before clamping to the configured maximum.
  localparam int unsigned VertexCountRst = 16;

  // Beat kind on the input channel.
  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

endpackage

`default_nettype wire

[hw/rtl/adjacency_to_incidence_converter_top.sv]
// A read beat passes through the edge table read stage, then the output stage, into the output
// register; write beats produce no result.
// Throughput: one beat per cycle, held off by a full output register or a busy divider. A
// vertex_count write holds the input off while a bit-serial divider re-derives row and
// column from the load position.
// Reset (rst_ni, asynchronous, active low) clears control state; edge tables need no clearing.
`default_nettype none

module adjacency_to_incidence_converter_top #(
  parameter int unsigned MAX_VERTICES = a2i_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = a2i_pkg::MaxEdgesDef,
  parameter int unsigned WEIGHT_BITS  = a2i_pkg::WeightBitsDef
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_we_i,
  input  logic [a2i_pkg::CfgW-1:0]                          cfg_wdata_i,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic                                              kind_i,
  input  logic signed [a2i_pkg::EntryW-1:0]                 entry_weight_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic signed [a2i_pkg::EntryW-1:0]                 incidence_value_o,
  output logic [$clog2(MAX_VERTICES)-1:0]                   vertex_row_o,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_column_o,
  output logic                                              last_in_row_o,
  output logic                                              last_overall_o,
  output logic                                              none_left_o
);
  import a2i_pkg::*;

  // Width bookkeeping. A vertex index needs VRowW bits; a vertex count up to
  // MAX_VERTICES needs NW bits. The load position counts up to MAX_VERTICES^2.
  localparam int unsigned VRowW   = $clog2(MAX_VERTICES);
  localparam int unsigned NW      = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EIdxW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECntW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned PosW    = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
  localparam int unsigned DivCntW = $clog2(PosW + 1);
  localparam int unsigned StoreW  = (WEIGHT_BITS < EntryW) ? WEIGHT_BITS : EntryW;
  localparam int unsigned NRst    = (VertexCountRst > MAX_VERTICES) ? MAX_VERTICES
                                                                    : VertexCountRst;

  // Configuration and load state.
  logic [NW-1:0]      n_q;
  logic [PosW-1:0]    pos_q;
  logic [VRowW-1:0]   row_q, col_q;
  logic [ECntW-1:0]   etot_q;
  logic               load_done_q;
  logic [NW-1:0]      rv_q;
  logic [EIdxW-1:0]   re_q;

  // Bit-serial divider that maps the load position onto row and column after
  // the vertex count changes.
  logic               div_busy_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [PosW-1:0]    div_num_q;
  logic [NW-1:0]      div_rem_q;
  logic [PosW-1:0]    div_quo_q;

  // Edge tables.
  logic [VRowW-1:0]   ep_a_mem [MAX_EDGES];
  logic [VRowW-1:0]   ep_b_mem [MAX_EDGES];
  logic [StoreW-1:0]  wt_mem   [MAX_EDGES];

  // Stage 1: read metadata plus registered table data.
  logic               s1_valid_q;
  logic               s1_none_q;
  logic [VRowW-1:0]   s1_v_q;
  logic [EIdxW-1:0]   s1_e_q;
  logic               s1_row_end_q;
  logic               s1_last_all_q;
  logic [VRowW-1:0]   rd_ep_a_q, rd_ep_b_q;
  logic [StoreW-1:0]  rd_wt_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [EntryW-1:0] out_value_q;
  logic [VRowW-1:0]         out_v_q;
  logic [EIdxW-1:0]         out_e_q;
  logic                     out_row_end_q, out_last_all_q, out_none_q;

  // Handshake and pipeline advance.
  logic in_fire, wr_fire, rd_fire, out_free, s1_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = (!s1_valid_q || out_free) && !div_busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_fire    = in_fire && (kind_e'(kind_i) == KIND_WRITE);
  assign rd_fire    = in_fire && (kind_e'(kind_i) == KIND_READ);

  // Clamp the written vertex count: zero acts as one, too large acts as the maximum.
  logic [NW-1:0] cfg_n;
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_n = NW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_VERTICES)) begin
      cfg_n = NW'(MAX_VERTICES);
    end else begin
      cfg_n = NW'(cfg_wdata_i);
    end
  end

  logic [2*NW-1:0] nn;
  assign nn = {{NW{1'b0}}, n_q} * {{NW{1'b0}}, n_q};

  // Write path. A write after a finished load starts a fresh matrix, so the
  // effective state is the cleared one in that case.
  logic [PosW-1:0]   wr_pos, pos_inc;
  logic [VRowW-1:0]  wr_row, wr_col;
  logic [ECntW-1:0]  wr_etot;
  logic [StoreW-1:0] w_store;
  logic              in_range, append, finish, col_wrap;

  always_comb begin
    wr_pos   = load_done_q ? '0 : pos_q;
    wr_row   = load_done_q ? '0 : row_q;
    wr_col   = load_done_q ? '0 : col_q;
    wr_etot  = load_done_q ? '0 : etot_q;
    w_store  = entry_weight_i[StoreW-1:0];
    in_range = (2*NW)'(wr_pos) < nn;
    append   = in_range && (w_store != '0) && (wr_col > wr_row) &&
               (wr_etot < ECntW'(MAX_EDGES));
    pos_inc  = wr_pos + PosW'(1);
    finish   = (2*NW)'(pos_inc) >= nn;
    col_wrap = ((NW+1)'(wr_col) + (NW+1)'(1)) == (NW+1)'(n_q);
  end

  // Read path. A read returns an entry only when the load is done, there are
  // edges, and the read position is still inside the matrix.
  logic rd_none, rd_row_end, rd_last_all;

  always_comb begin
    rd_none     = !load_done_q || (etot_q == '0) || (rv_q >= n_q) ||
                  (ECntW'(re_q) >= etot_q);
    rd_row_end  = (ECntW'(re_q) + ECntW'(1)) == etot_q;
    rd_last_all = rd_row_end && (((NW+1)'(rv_q) + (NW+1)'(1)) == (NW+1)'(n_q));
  end

  // Divider step: restoring division, one quotient bit per cycle.
  logic [NW:0]     div_rem_sh;
  logic            div_ge;
  logic [NW-1:0]   div_rem_nx;
  logic [PosW-1:0] div_quo_nx;

  always_comb begin
    div_rem_sh = {div_rem_q, div_num_q[PosW-1]};
    div_ge     = div_rem_sh >= (NW+1)'(n_q);
    div_rem_nx = div_ge ? NW'(div_rem_sh - (NW+1)'(n_q)) : NW'(div_rem_sh);
    div_quo_nx = {div_quo_q[PosW-2:0], div_ge};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= NW'(NRst);
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      etot_q      <= '0;
      load_done_q <= 1'b0;
      rv_q        <= '0;
      re_q        <= '0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      div_num_q   <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q        <= cfg_n;
        div_busy_q <= 1'b1;
        div_cnt_q  <= DivCntW'(PosW);
        div_num_q  <= pos_q;
        div_rem_q  <= '0;
        div_quo_q  <= '0;
      end else if (div_busy_q) begin
        div_num_q <= {div_num_q[PosW-2:0], 1'b0};
        div_rem_q <= div_rem_nx;
        div_quo_q <= div_quo_nx;
        div_cnt_q <= div_cnt_q - DivCntW'(1);
        if (div_cnt_q == DivCntW'(1)) begin
          div_busy_q <= 1'b0;
          row_q      <= div_quo_nx[VRowW-1:0];
          col_q      <= div_rem_nx[VRowW-1:0];
        end
      end else if (wr_fire) begin
        pos_q <= pos_inc;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= wr_row + VRowW'(1);
        end else begin
          col_q <= wr_col + VRowW'(1);
          row_q <= wr_row;
        end
      end

      if (wr_fire) begin
        etot_q      <= append ? wr_etot + ECntW'(1) : wr_etot;
        load_done_q <= finish;
        if (load_done_q || finish) begin
          rv_q <= '0;
          re_q <= '0;
        end
      end else if (rd_fire && !rd_none) begin
        if (rd_row_end) begin
          re_q <= '0;
          rv_q <= rv_q + NW'(1);
        end else begin
          re_q <= re_q + EIdxW'(1);
        end
      end

      if (rd_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Edge tables: one write port on append, one registered read port per read beat.
  always_ff @(posedge clk_i) begin
    if (wr_fire && append) begin
      ep_a_mem[wr_etot[EIdxW-1:0]] <= wr_row;
      ep_b_mem[wr_etot[EIdxW-1:0]] <= wr_col;
      wt_mem[wr_etot[EIdxW-1:0]]   <= w_store;
    end
    if (rd_fire) begin
      rd_ep_a_q <= ep_a_mem[re_q];
      rd_ep_b_q <= ep_b_mem[re_q];
      rd_wt_q   <= wt_mem[re_q];
    end
  end

  // Stage 1 metadata. Fields are forced to zero when nothing is returned.
  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      s1_none_q     <= rd_none;
      s1_v_q        <= rd_none ? '0 : rv_q[VRowW-1:0];
      s1_e_q        <= rd_none ? '0 : re_q;
      s1_row_end_q  <= !rd_none && rd_row_end;
      s1_last_all_q <= !rd_none && rd_last_all;
    end
  end

  // Output payload: the weight appears only where the vertex is an endpoint.
  logic touches;
  assign touches = !s1_none_q && ((rd_ep_a_q == s1_v_q) || (rd_ep_b_q == s1_v_q));

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q    <= touches ? $signed(EntryW'(rd_wt_q)) : '0;
      out_v_q        <= s1_v_q;
      out_e_q        <= s1_e_q;
      out_row_end_q  <= s1_row_end_q;
      out_last_all_q <= s1_last_all_q;
      out_none_q     <= s1_none_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign incidence_value_o = out_value_q;
  assign vertex_row_o      = out_v_q;
  assign edge_column_o     = out_e_q;
  assign last_in_row_o     = out_row_end_q;
  assign last_overall_o    = out_last_all_q;
  assign none_left_o       = out_none_q;

  // An empty result carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_left_o) |-> (incidence_value_o == '0 && !last_in_row_o &&
                                      !last_overall_o && edge_column_o == '0))
    else $error("empty result with nonzero fields");

  // The final entry of the matrix always closes its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_overall_o) |-> last_in_row_o)
    else $error("last_overall without last_in_row");

  // The edge count never grows past the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    etot_q <= ECntW'(MAX_EDGES))
    else $error("edge count beyond table depth");

  // No beat is taken as the divider starts re-deriving row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_busy_q) |-> !in_fire)
    else $error("beat accepted during divide");

endmodule

`default_nettype wire
